[sv/clt_pkg.sv]
// Shared types, constants and small lookup functions for the C lexer token splitter.
// No dependencies; every other file takes names from here by scope.
package clt_pkg;

  localparam int POSITION_BITS   = 32;
  localparam int LENGTH_BITS     = 16;
  localparam int KEYWORD_MAX_LEN = 10;

  localparam int START_W  = 32;
  localparam int OLEN_W   = 16;
  localparam int KIND_W   = 6;
  localparam int NUM_KW   = 32;
  localparam int KW_CHARS = 8;
  localparam int NUM_SEP  = 12;
  localparam int SEP_IDX_W = 4;

  localparam int Q_DEPTH = 4;
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0]   wlen_t;
  typedef logic [START_W-1:0]       start_t;
  typedef logic [OLEN_W-1:0]        olen_t;
  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [1:0]               push_t;

  localparam kind_t KIND_WORD = kind_t'(0);
  localparam kind_t KIND_INT  = kind_t'(1);
  localparam kind_t KIND_KW0  = kind_t'(2);
  localparam kind_t KIND_SEP0 = kind_t'(34);

  localparam push_t PUSH_NONE = 2'd0;
  localparam push_t PUSH_ONE  = 2'd1;
  localparam push_t PUSH_TWO  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";

  // Keywords, space padded to eight characters, first character in the top byte.
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KW] = '{
    "auto    ", "double  ", "int     ", "struct  ", "break   ", "else    ",
    "long    ", "switch  ", "case    ", "enum    ", "register", "typedef ",
    "char    ", "extern  ", "return  ", "union   ", "continue", "for     ",
    "signed  ", "void    ", "do      ", "if      ", "static  ", "while   ",
    "default ", "goto    ", "sizeof  ", "volatile", "const   ", "float   ",
    "short   ", "unsigned"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd6, 4'd3, 4'd6, 4'd5, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd8, 4'd7,
    4'd4, 4'd6, 4'd6, 4'd5, 4'd8, 4'd3, 4'd6, 4'd4, 4'd2, 4'd2, 4'd6, 4'd5,
    4'd7, 4'd4, 4'd6, 4'd8, 4'd5, 4'd5, 4'd5, 4'd8
  };

  localparam logic [7:0] SEP_CHARS [NUM_SEP] = '{
    "#", "(", ")", "{", "}", "[", "]", ";", "<", ">", ",", "\""
  };

  typedef struct packed {
    start_t start;
    olen_t  length;
    kind_t  kind;
    logic   last;
  } tok_t;

  typedef struct packed {
    logic hit;
    logic [SEP_IDX_W-1:0] idx;
  } sep_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic room;
    logic valid;
  } q_stat_t;

  function automatic sep_t sep_lookup(input logic [7:0] c);
    sep_t r;
    r = '0;
    for (int i = 0; i < NUM_SEP; i++) begin
      if (c == SEP_CHARS[i]) begin
        r.hit = 1'b1;
        r.idx = SEP_IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_VT);
  endfunction

endpackage

[sv/clt_kind.sv]
// Word classifier: integer test and parallel compare against the 32 keywords.
// Depends on clt_pkg.
module clt_kind (
  input  logic [7:0]     prefix [clt_pkg::KEYWORD_MAX_LEN],
  input  clt_pkg::wlen_t len,
  input  logic           digits,
  output clt_pkg::kind_t kind
);

  logic match;
  logic hit;

  always_comb begin
    kind  = clt_pkg::KIND_WORD;
    hit   = 1'b0;
    match = 1'b0;
    for (int k = 0; k < clt_pkg::NUM_KW; k++) begin
      match = (len == clt_pkg::wlen_t'(clt_pkg::KW_LEN[k]));
      for (int j = 0; j < clt_pkg::KW_CHARS; j++) begin
        if ((4'(j) < clt_pkg::KW_LEN[k]) &&
            (prefix[j] != clt_pkg::KW_TEXT[k][8*clt_pkg::KW_CHARS-1-8*j -: 8])) begin
          match = 1'b0;
        end
      end
      if (match && !hit) begin
        hit  = 1'b1;
        kind = clt_pkg::KIND_KW0 + clt_pkg::kind_t'(k);
      end
    end
    // all-digit words are integers, never keywords
    if (digits) begin
      kind = clt_pkg::KIND_INT;
    end
  end

endmodule

[sv/clt_scan.sv]
// Byte scanner: word state, position counter and token generation (up to two per byte).
// Depends on clt_pkg and clt_kind.
module clt_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [7:0]     char_byte,
  input  logic           end_of_input,
  output clt_pkg::tok_t  tok0,
  output clt_pkg::tok_t  tok1,
  output clt_pkg::push_t push_n
);

  clt_pkg::pos_t  pos_r, pos_nxt;
  clt_pkg::wlen_t len_r, len_nxt;
  clt_pkg::pos_t  start_r, start_nxt;
  logic           digits_r, digits_nxt;
  logic [7:0]     prefix_r   [clt_pkg::KEYWORD_MAX_LEN];
  logic [7:0]     prefix_nxt [clt_pkg::KEYWORD_MAX_LEN];

  clt_pkg::sep_t  sep;
  logic           is_word;
  logic           is_dig;
  logic           flush;

  // word state as it stands after a word byte
  clt_pkg::wlen_t wlen_upd;
  clt_pkg::pos_t  wstart_upd;
  logic           wdig_upd;
  logic [7:0]     wprefix_upd [clt_pkg::KEYWORD_MAX_LEN];

  logic [7:0]     k_prefix [clt_pkg::KEYWORD_MAX_LEN];
  clt_pkg::wlen_t k_len;
  logic           k_digits;
  clt_pkg::kind_t k_kind;

  clt_pkg::tok_t  word_tok;
  clt_pkg::tok_t  sep_tok;

  assign sep     = clt_pkg::sep_lookup(char_byte);
  assign is_word = !sep.hit && !clt_pkg::is_space(char_byte);
  assign is_dig  = (char_byte >= clt_pkg::CH_0) && (char_byte <= clt_pkg::CH_9);

  always_comb begin
    wlen_upd   = (len_r == '1) ? len_r : len_r + 1'b1;
    wstart_upd = (len_r == '0) ? pos_r : start_r;
    wdig_upd   = ((len_r == '0) ? 1'b1 : digits_r) & is_dig;
    for (int i = 0; i < clt_pkg::KEYWORD_MAX_LEN; i++) begin
      wprefix_upd[i] = (len_r == clt_pkg::wlen_t'(i)) ? char_byte : prefix_r[i];
    end
  end

  // classifier sees the updated word when a word byte ends the input
  always_comb begin
    for (int i = 0; i < clt_pkg::KEYWORD_MAX_LEN; i++) begin
      k_prefix[i] = is_word ? wprefix_upd[i] : prefix_r[i];
    end
    k_len    = is_word ? wlen_upd : len_r;
    k_digits = is_word ? wdig_upd : digits_r;
  end

  clt_kind u_kind (
    .prefix (k_prefix),
    .len    (k_len),
    .digits (k_digits),
    .kind   (k_kind)
  );

  assign flush = is_word ? end_of_input : (len_r != '0);

  always_comb begin
    word_tok.start  = clt_pkg::start_t'(is_word ? wstart_upd : start_r);
    word_tok.length = clt_pkg::olen_t'(k_len);
    word_tok.kind   = k_kind;
    word_tok.last   = !sep.hit;

    sep_tok.start  = clt_pkg::start_t'(pos_r);
    sep_tok.length = clt_pkg::olen_t'(1);
    sep_tok.kind   = clt_pkg::KIND_SEP0 + clt_pkg::kind_t'(sep.idx);
    sep_tok.last   = 1'b1;

    tok0 = flush ? word_tok : sep_tok;
    tok1 = sep_tok;
    if (!en) begin
      push_n = clt_pkg::PUSH_NONE;
    end else begin
      push_n = clt_pkg::push_t'(flush) + clt_pkg::push_t'(sep.hit);
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    digits_nxt = digits_r;
    prefix_nxt = prefix_r;
    if (en) begin
      pos_nxt = pos_r + 1'b1;
      if (is_word) begin
        len_nxt    = wlen_upd;
        start_nxt  = wstart_upd;
        digits_nxt = wdig_upd;
        prefix_nxt = wprefix_upd;
      end else begin
        len_nxt    = '0;
        start_nxt  = '0;
        digits_nxt = 1'b1;
      end
      if (end_of_input) begin
        pos_nxt    = '0;
        len_nxt    = '0;
        start_nxt  = '0;
        digits_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      start_r  <= '0;
      digits_r <= 1'b1;
    end else begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      start_r  <= start_nxt;
      digits_r <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
  end

endmodule

[sv/clt_outq.sv]
// Result queue: four token slots, takes up to two tokens a cycle, slot 0 drives the output.
// Depends on clt_pkg.
module clt_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::push_t   push_n,
  input  clt_pkg::tok_t    tok0,
  input  clt_pkg::tok_t    tok1,
  input  logic             pop_ready,
  output clt_pkg::tok_t    head,
  output clt_pkg::q_stat_t stat
);

  clt_pkg::tok_t q_r   [clt_pkg::Q_DEPTH];
  clt_pkg::tok_t q_nxt [clt_pkg::Q_DEPTH];
  clt_pkg::cnt_t cnt_r, cnt_nxt;
  clt_pkg::cnt_t base;
  logic          pop;

  assign pop  = pop_ready && (cnt_r != '0);
  assign base = pop ? cnt_r - 1'b1 : cnt_r;

  always_comb begin
    for (int i = 0; i < clt_pkg::Q_DEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[clt_pkg::Q_DEPTH-1] = q_r[clt_pkg::Q_DEPTH-1];
    for (int i = 0; i < clt_pkg::Q_DEPTH; i++) begin
      if ((push_n != clt_pkg::PUSH_NONE) && (base == clt_pkg::cnt_t'(i))) begin
        q_nxt[i] = tok0;
      end
      if ((push_n == clt_pkg::PUSH_TWO) && (base + 1'b1 == clt_pkg::cnt_t'(i))) begin
        q_nxt[i] = tok1;
      end
    end
    cnt_nxt = base + clt_pkg::cnt_t'(push_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign head       = q_r[0];
  assign stat.valid = (cnt_r != '0);
  assign stat.room  = (cnt_r <= clt_pkg::cnt_t'(clt_pkg::Q_DEPTH - 2));

endmodule

[sv/c_lexer_token_splitter.sv]
// Top level of the C lexer token splitter: input register, byte scanner, result queue.
// Depends on clt_pkg, clt_scan (with clt_kind) and clt_outq.
//
//   channel | direction | request fields
//   --------+-----------+---------------------------------------------------------------
//   in_     | input     | char_byte[7:0], end_of_input
//   out_    | output    | token_start[31:0], token_length[15:0], token_kind[5:0],
//           |           | last_of_run
//
// One byte per cycle while the queue has room: a byte sits in the input register, is
// scanned and its tokens land in the queue in the next cycle. The queue is four tokens deep
// and the scanner runs whenever at most two are waiting, so the output port (one token per
// cycle) is the only limit; a byte that ends a word and is a separator yields two tokens.
// Reset (rst_n low, synchronous) clears the position, the word state and both valid flags.
// A stalled output fills the queue, then holds the input register, then drops in_ready.
module c_lexer_token_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [5:0]  out_token_kind,
  output logic        out_last_of_run
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_char_r;
  logic       in_eoi_r;

  logic             adv;      // scanner consumes the registered byte this cycle
  clt_pkg::q_stat_t q_stat;
  clt_pkg::tok_t    tok0;
  clt_pkg::tok_t    tok1;
  clt_pkg::push_t   push_n;
  clt_pkg::tok_t    head;

  assign adv      = in_v_r && q_stat.room;
  assign in_ready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_byte;
      in_eoi_r  <= in_end_of_input;
    end
  end

  clt_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .char_byte    (in_char_r),
    .end_of_input (in_eoi_r),
    .tok0         (tok0),
    .tok1         (tok1),
    .push_n       (push_n)
  );

  clt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .tok0      (tok0),
    .tok1      (tok1),
    .pop_ready (out_ready),
    .head      (head),
    .stat      (q_stat)
  );

  assign out_valid        = q_stat.valid;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_token_kind   = head.kind;
  assign out_last_of_run  = head.last;

  // a two-token byte is always a word followed by its separator
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == clt_pkg::PUSH_TWO) |->
      (tok0.kind < clt_pkg::KIND_SEP0) && (tok1.kind >= clt_pkg::KIND_SEP0))
    else $error("two-token byte not word then separator");

  // exactly the final token of a byte carries last_of_run
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != clt_pkg::PUSH_NONE) |->
      ((push_n == clt_pkg::PUSH_ONE) && tok0.last) ||
      ((push_n == clt_pkg::PUSH_TWO) && !tok0.last && tok1.last))
    else $error("last_of_run misplaced");

  // no empty token reaches the output
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_length != '0))
    else $error("zero-length token");

  // a byte held back by a full queue stays in the input register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !q_stat.room) |=> in_v_r)
    else $error("stalled byte lost");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for c_lexer_token_splitter: streams source bytes and predicts every token.
// Depends on clt_pkg (token struct, kind codes) and the splitter RTL.
module tb_top;

  // Bytes of a word kept for keyword compare; longer keywords never exist.
  localparam int PREFIX_SLOTS  = 10;
  localparam int RANDOM_ITEMS  = 640;
  // Receiver hold-off used to fill the token queue and stall the input.
  localparam int HOLD_CYCLES   = 150;
  // Pipeline is the input register and scanner plus a four-deep queue; this is plenty.
  localparam int DRAIN_CYCLES  = 20;
  // Well past the kept word prefix, so keyword compare sees a long word.
  localparam int LONG_WORD_LEN = 40;

  localparam logic [7:0] BL_SPACE = 8'h20;
  localparam logic [7:0] BL_LF    = 8'h0A;
  localparam logic [7:0] BL_TAB   = 8'h09;
  localparam logic [7:0] BL_VT    = 8'h0B;
  localparam logic [7:0] BLANKS [4] = '{BL_SPACE, BL_LF, BL_TAB, BL_VT};

  // Separators in kind order, first one in the top byte.
  localparam int NUM_SEPS = 12;
  localparam logic [8*NUM_SEPS-1:0] SEP_SET = "#(){}[];<>,\"";

  // Keywords in kind order: kind = KIND_KW0 + index.
  string kw_list [32] = '{
    "auto", "double", "int", "struct", "break", "else", "long", "switch",
    "case", "enum", "register", "typedef", "char", "extern", "return",
    "union", "continue", "for", "signed", "void", "do", "if", "static",
    "while", "default", "goto", "sizeof", "volatile", "const", "float",
    "short", "unsigned"
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_token_start;
  logic [15:0] out_token_length;
  logic [5:0]  out_token_kind;
  logic        out_last_of_run;

  // Lexer state mirrored by the predictor.
  logic [31:0] lex_pos;
  logic [15:0] word_len;
  logic [7:0]  word_prefix [PREFIX_SLOTS];
  logic        word_digits;
  logic [31:0] word_start;

  clt_pkg::tok_t token_q [$];   // tokens owed by the block, oldest first
  int   errors;
  int   bytes_sent;
  int   burst_left;    // requests left in the current sender burst
  bit   hold_req;      // asks the receiver for one long hold-off

  c_lexer_token_splitter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_token_kind   (out_token_kind),
    .out_last_of_run  (out_last_of_run)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return c == BL_SPACE || c == BL_LF || c == BL_TAB || c == BL_VT;
  endfunction

  // Separator index, -1 for any other byte.
  function automatic int sep_index(input logic [7:0] c);
    for (int i = 0; i < NUM_SEPS; i++)
      if (SEP_SET[8*(NUM_SEPS-1-i) +: 8] == c) return i;
    return -1;
  endfunction

  // Kind of the pending word. Digits win over keywords; a saturated length
  // is far above any keyword length, so it can never match.
  function automatic clt_pkg::kind_t kind_of_word();
    bit same;
    if (word_digits) return clt_pkg::KIND_INT;
    for (int k = 0; k < 32; k++) begin
      if (word_len == kw_list[k].len()) begin
        same = 1'b1;
        for (int j = 0; j < kw_list[k].len(); j++)
          if (word_prefix[j] != kw_list[k][j]) same = 1'b0;
        if (same) return clt_pkg::kind_t'(clt_pkg::KIND_KW0 + k);
      end
    end
    return clt_pkg::KIND_WORD;
  endfunction

  function automatic clt_pkg::tok_t make_tok(input logic [31:0] start, input logic [15:0] len,
                                             input clt_pkg::kind_t kind);
    clt_pkg::tok_t t;
    t.start  = start;
    t.length = len;
    t.kind   = kind;
    t.last   = 1'b0;
    return t;
  endfunction

  // Advance the mirrored lexer by one accepted request and queue its tokens.
  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    clt_pkg::tok_t fresh [$];
    int   sidx;
    sidx = sep_index(c);
    if (sidx >= 0 || is_blank(c)) begin
      // word boundary: the word goes out ahead of any separator
      if (word_len != 0) begin
        fresh = {fresh, make_tok(word_start, word_len, kind_of_word())};
        word_len    = '0;
        word_digits = 1'b1;
      end
    end else begin
      // any other byte, control and high bytes included, extends the word
      if (word_len == 0) begin
        word_start  = lex_pos;
        word_digits = 1'b1;
      end
      if (word_len < PREFIX_SLOTS) word_prefix[word_len] = c;
      if (c < "0" || c > "9") word_digits = 1'b0;
      if (word_len != '1) word_len++;
    end
    if (sidx >= 0)
      fresh = {fresh, make_tok(lex_pos, 16'd1, clt_pkg::kind_t'(clt_pkg::KIND_SEP0 + sidx))};
    lex_pos++;
    if (eoi) begin
      // flush whatever is pending and restart counting at zero
      if (word_len != 0) fresh = {fresh, make_tok(word_start, word_len, kind_of_word())};
      word_len    = '0;
      word_digits = 1'b1;
      lex_pos     = '0;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    token_q = {token_q, fresh};
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; drives at the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      // one burst in three follows straight on with no gap
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_char_byte    = c;
    in_end_of_input = eoi;
    // hold the request until the block takes it
    do @(posedge clk); while (!in_ready);
    lex_byte(c, eoi);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit eoi_on_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eoi_on_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready runs and stalls of its own; one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int on_len;
    int off_len;
    out_ready = 1'b0;
    forever begin
      on_len  = $urandom_range(1, 30);
      off_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (on_len) begin
        @(negedge clk);
        if (hold_req) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        out_ready = 1'b1;
      end
      repeat (off_len) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every token taken at a rising edge against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_tokens
    clt_pkg::tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $error("token with no request behind it: start %0d kind %0d",
               out_token_start, out_token_kind);
        errors++;
      end else begin
        want = token_q.pop_front();
        if (out_token_start !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, out_token_start);
          errors++;
        end
        if (out_token_length !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, out_token_length);
          errors++;
        end
        if (out_token_kind !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Word cut short by a separator, then all twelve separators back to back.
  task automatic test_separators();
    send_text("x#(){}[];<>,\"", 1'b0);
  endtask

  task automatic test_word_kinds();
    send_byte(8'h00, 1'b0);            // NUL and 0xFF are plain word bytes
    send_byte(8'hFF, 1'b0);
    send_byte(BL_VT, 1'b0);            // vertical tab ends the word
    send_text("longswitch\t", 1'b0);   // the two keywords run together: plain word
    send_text("7\n", 1'b0);
    send_text("y", 1'b1);              // end of input flushes the pending word
    send_text("ab)", 1'b1);            // word and separator off one byte, then end
    send_text(" ", 1'b1);              // end on a blank: no token at all
  endtask

  // Separator-heavy text while the receiver holds off: queue fills, in_ready drops.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (3) send_text("f(a);g[b];{c}", 1'b0);
  endtask

  // Digits well past the kept prefix, then a letter flagged as end of input:
  // the word turns plain, its length counts every byte and its start is exact.
  task automatic test_long_word();
    for (int i = 0; i < LONG_WORD_LEN - 1; i++)
      send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_byte("z", 1'b1);
  endtask

  // Mostly C-like token streams; the rest is near-miss keywords and raw noise.
  task automatic test_random();
    logic [7:0] lex [$];
    int start_count;
    int pick;
    int k;
    int n;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_ITEMS) begin
      lex.delete();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // keyword; the first quarter get bent into near misses
        k = $urandom_range(0, 31);
        n = kw_list[k].len();
        for (int j = 0; j < n; j++) lex = {lex, 8'(kw_list[k][j])};
        if (pick < 10) begin
          if ($urandom_range(0, 1) == 1) void'(lex.pop_back());
          else lex = {lex, rand_word_char()};
        end
      end else if (pick < 52) begin
        n = $urandom_range(1, 12);
        repeat (n) lex = {lex, 8'("0" + $urandom_range(0, 9))};
      end else if (pick < 70) begin
        n = $urandom_range(1, 14);
        repeat (n) lex = {lex, rand_word_char()};
      end else if (pick < 88) begin
        lex = {lex, SEP_SET[8*$urandom_range(0, NUM_SEPS-1) +: 8]};
      end else begin
        lex = {lex, 8'($urandom_range(0, 255))};
      end
      // words mostly end on a blank or separator; sometimes they run on
      if (pick < 70 && $urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 2) == 0)
          lex = {lex, SEP_SET[8*$urandom_range(0, NUM_SEPS-1) +: 8]};
        else
          lex = {lex, BLANKS[$urandom_range(0, 3)]};
      end
      // end of input lands on any kind of byte now and then
      foreach (lex[j]) send_byte(lex[j], $urandom_range(0, 49) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_char_byte    = 8'h00;
    in_end_of_input = 1'b0;
    lex_pos         = '0;
    word_len        = '0;
    word_digits     = 1'b1;
    word_start      = '0;
    errors          = 0;
    bytes_sent      = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_separators();
    test_word_kinds();
    test_backpressure();
    test_long_word();
    test_random();

    @(negedge clk);
    in_valid = 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    // anything arriving now is a stray token and fails in the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: several times the slowest legal run (widest gaps, longest stalls).
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
